// ===== hdl/smpq_pkg.sv =====
// Shared types and constants for the sorted minimum priority queue.
`default_nettype none
package smpq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 5;
  localparam int STATUS_W     = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL_DROP  = 2'd2;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [VALUE_W-1:0] value;
  } ctrl_t;

  // What a cell shows its neighbours.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               occ;
    logic               move;
  } link_t;

endpackage
`default_nettype wire

// ===== hdl/smpq_cell.sv =====
// One slot of the sorted chain: holds a value and an occupied flag.
`default_nettype none
module smpq_cell
  import smpq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctrl_t ctrl,
  input  wire link_t left_in,
  input  wire link_t right_in,
  output link_t      link_out
);

  logic [VALUE_W-1:0] value;
  logic               occ;
  logic               move;

  // Empty or holding a larger value: this slot shifts right on insert.
  // Equal values stay put, so a new value lands after them.
  assign move = !occ || ($signed(value) > $signed(ctrl.value));

  assign link_out.value = value;
  assign link_out.occ   = occ;
  assign link_out.move  = move;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (move) begin
        value <= left_in.move ? left_in.value : ctrl.value;
      end
    end else if (ctrl.rem) begin
      value <= right_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.ins) begin
      occ <= left_in.occ;
    end else if (ctrl.rem) begin
      occ <= right_in.occ;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sorted_min_priority_queue.sv =====
// Top level: sorted minimum priority queue built as a chain of slot cells.
// The result is registered and shows in the cycle after the input transaction.
// Throughput: one transaction per cycle while out_ready keeps the output free;
// every cell compares against the broadcast value in parallel, shifting data by one slot.
// Reset clears the occupied flags, the count and the output valid;
// stored values are not cleared.
`default_nettype none
module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   opcode,
  input  wire logic signed [VALUE_W-1:0] insert_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [VALUE_W-1:0]   removed_value,
  output logic                        removed_valid,
  output logic [COUNT_OUT_W-1:0]      entry_count,
  output logic [STATUS_W-1:0]         status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic          accept;
  logic          full;
  logic          empty;
  logic [CW-1:0] count;
  ctrl_t         ctrl;
  link_t         links [CAPACITY];
  link_t         lefts [CAPACITY];
  link_t         rights [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign empty    = !links[0].occ;
  assign full     = links[CAPACITY-1].occ;

  assign ctrl.ins   = accept && (opcode == OP_INSERT) && !full;
  assign ctrl.rem   = accept && (opcode == OP_REMOVE) && !empty;
  assign ctrl.value = insert_value;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign lefts[g] = '{value: '0, occ: 1'b1, move: 1'b0};
      end else begin : g_mid
        assign lefts[g] = links[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign rights[g] = '{value: '0, occ: 1'b0, move: 1'b0};
      end else begin : g_body
        assign rights[g] = links[g+1];
      end
      smpq_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .left_in  (lefts[g]),
        .right_in (rights[g]),
        .link_out (links[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins) begin
      count <= count + CW'(1);
    end else if (ctrl.rem) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= '0;
      removed_valid <= 1'b0;
      status        <= STATUS_OK;
      entry_count   <= COUNT_OUT_W'(count);
      case (opcode)
        OP_INSERT: begin
          if (full) begin
            status <= STATUS_FULL_DROP;
          end else begin
            entry_count <= COUNT_OUT_W'(count + CW'(1));
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status <= STATUS_EMPTY;
          end else begin
            removed_value <= links[0].value;
            removed_valid <= 1'b1;
            entry_count   <= COUNT_OUT_W'(count - CW'(1));
          end
        end
        default: begin
          status <= STATUS_OK;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/sorted_min_priority_queue_tb.sv =====
// Testbench for the sorted minimum priority queue: random handshakes, self-checking.
module sorted_min_priority_queue_tb;
  import smpq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = CAPACITY_DEF;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_OPS   = 1000;
  localparam int DRAIN_EVERY  = 250;
  localparam int REPORT_LIMIT = 20;
  localparam logic signed [VALUE_W-1:0] MAX_VAL = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] MIN_VAL = 32'sh80000000;

  typedef struct {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    bit                        drain;  // hold off until all results are back
  } queue_op_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic [COUNT_OUT_W-1:0]    count;
    logic [STATUS_W-1:0]       status;
  } outcome_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic                      opcode       = OP_INSERT;
  logic signed [VALUE_W-1:0] insert_value = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic signed [VALUE_W-1:0] removed_value;
  logic                      removed_valid;
  logic [COUNT_OUT_W-1:0]    entry_count;
  logic [STATUS_W-1:0]       status;

  queue_op_t                 ops_to_send[$];
  outcome_t                  due_results[$];
  logic signed [VALUE_W-1:0] held_vals[$];  // ascending, mirrors the slot chain

  int errors       = 0;
  int total_ops    = 0;
  int sent_cnt     = 0;
  int n_inserts    = 0;
  int n_removes    = 0;
  int n_empty_rem  = 0;
  int n_full_drop  = 0;
  int n_reach_full = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int wr_calm      = 0;
  int rd_calm      = 0;
  int quiet        = 0;

  sorted_min_priority_queue #(.CAPACITY(CAP)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .insert_value (insert_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .removed_value(removed_value),
    .removed_valid(removed_valid),
    .entry_count  (entry_count),
    .status       (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return int'($urandom_range(0, 6)) - 3;  // narrow band, many ties
      7:          return MAX_VAL;
      8:          return MIN_VAL;
      default:    return $urandom_range(0, 1) ? MAX_VAL - $urandom_range(0, 3)
                                              : MIN_VAL + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic add_op(logic op, logic signed [VALUE_W-1:0] v, bit drain);
    queue_op_t q;
    q.op    = op;
    q.value = v;
    q.drain = drain;
    ops_to_send.push_back(q);
  endtask

  // Sorted-list priority queue: ties go behind existing equal entries.
  function automatic outcome_t queue_step(logic op, logic signed [VALUE_W-1:0] v);
    outcome_t r;
    int pos;
    r = '0;
    if (op == OP_INSERT) begin
      n_inserts++;
      if (held_vals.size() >= CAP) begin
        r.status = STATUS_FULL_DROP;
        n_full_drop++;
      end else begin
        pos = held_vals.size();
        for (int i = 0; i < held_vals.size(); i++) begin
          if (held_vals[i] > v) begin
            pos = i;
            break;
          end
        end
        held_vals.insert(pos, v);
        if (held_vals.size() == CAP) n_reach_full++;
      end
    end else begin
      n_removes++;
      if (held_vals.size() == 0) begin
        r.status = STATUS_EMPTY;
        n_empty_rem++;
      end else begin
        r.value = held_vals.pop_front();
        r.valid = 1'b1;
      end
    end
    r.count = COUNT_OUT_W'(held_vals.size());
    return r;
  endfunction

  task automatic check_field(string field, logic signed [VALUE_W-1:0] want,
                             logic signed [VALUE_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Driver
  always @(posedge clk) begin
    logic      nv;
    queue_op_t cur;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        due_results.push_back(queue_step(opcode, insert_value));
        sent_cnt++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (ops_to_send.size() > 0 &&
                     !(ops_to_send[0].drain && due_results.size() > 0)) begin
          cur = ops_to_send.pop_front();
          opcode       <= cur.op;
          insert_value <= cur.value;
          nv = 1'b1;
          gap_left = idle_len(wr_calm);
        end
      end
      in_valid <= nv;
    end
  end

  // Monitor
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing outstanding", $time);
        end else begin
          want = due_results.pop_front();
          check_field("removed_value", want.value, removed_value);
          check_field("removed_valid", VALUE_W'(want.valid), VALUE_W'(removed_valid));
          check_field("entry_count", VALUE_W'(want.count), VALUE_W'(entry_count));
          check_field("status", VALUE_W'(want.status), VALUE_W'(status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_len(rd_calm);
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("** sorted_min_priority_queue: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    mix_t mix;
    int   mix_left;
    int   ins_pct;

    // remove on empty, extremes, ties, partial drain, fill, insert when full
    add_op(OP_REMOVE, 32'sh5a5a5a5a, 1'b0);
    add_op(OP_INSERT, MAX_VAL, 1'b0);
    add_op(OP_INSERT, MIN_VAL, 1'b0);
    add_op(OP_INSERT, 0, 1'b0);
    add_op(OP_INSERT, -1, 1'b0);
    add_op(OP_INSERT, 1, 1'b0);
    add_op(OP_INSERT, 5, 1'b0);
    add_op(OP_INSERT, 5, 1'b0);
    add_op(OP_REMOVE, -1, 1'b0);
    add_op(OP_REMOVE, 0, 1'b0);
    for (int i = 0; i < CAP - 5; i++) add_op(OP_INSERT, $urandom, 1'b0);
    add_op(OP_INSERT, MIN_VAL, 1'b0);
    add_op(OP_REMOVE, MAX_VAL, 1'b0);

    mix_left = 0;
    mix = MIX_EVEN;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (mix_left == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        mix_left = $urandom_range(10, 60);
      end
      mix_left--;
      case (mix)
        MIX_FILL:  ins_pct = 80;
        MIX_DRAIN: ins_pct = 25;
        default:   ins_pct = 50;
      endcase
      if ($urandom_range(0, 99) < ins_pct)
        add_op(OP_INSERT, pick_value(), n % DRAIN_EVERY == 0);
      else
        add_op(OP_REMOVE, $urandom, n % DRAIN_EVERY == 0);
    end
    total_ops = ops_to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sent_cnt < total_ops) @(negedge clk);
    while (due_results.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d transactions: %0d inserts, %0d removes.", total_ops, n_inserts, n_removes);
    $display("Removes on empty: %0d, inserts dropped when full: %0d, filled to capacity %0d times.",
             n_empty_rem, n_full_drop, n_reach_full);
    if (errors == 0)
      $display("** sorted_min_priority_queue: PASSED **");
    else
      $display("** sorted_min_priority_queue: FAILED **");
    $finish;
  end

endmodule
